// ===== hw/rtl/sses_pkg.sv =====
`timescale 1ns / 1ps

package sses_pkg;

  // Fixed-point format of the filters: tenths of a unit, scaled by 2^FRACTION_BITS.
  localparam int FRACTION_BITS = 16;

  // Field widths of the channels.
  localparam int TIME_W    = 32;
  localparam int HUM_IN_W  = 10;
  localparam int TMP_IN_W  = 11;
  localparam int HND_W     = 14;
  localparam int LOG_MIN_W = 17;

  // Filter storage and working widths.
  localparam int HUM_W  = FRACTION_BITS + HUM_IN_W;
  localparam int TMP_W  = FRACTION_BITS + TMP_IN_W + 1;
  localparam int FILT_W = FRACTION_BITS + TMP_IN_W + 1;

  // Divide by 20: magnitude, drop two bits, then a reciprocal multiply by 1/5.
  localparam int MAG_W      = FRACTION_BITS + TMP_IN_W;
  localparam int DIVA_W     = MAG_W - 2;
  localparam int DIV5_SHIFT = DIVA_W + 3;
  localparam int RCP_W      = DIVA_W + 1;
  localparam int PROD_W     = DIVA_W + RCP_W;
  localparam int QUO_W      = PROD_W - DIV5_SHIFT;
  localparam logic [RCP_W-1:0] DIV5_RCP =
      RCP_W'(((64'd1 << DIV5_SHIFT) + 64'd4) / 64'd5);
  localparam logic [MAG_W-1:0] ROUND_UP_19 = MAG_W'(19);

  // Report arithmetic: 10 * y + 0.5 tenth, then drop the fraction bits.
  localparam int REP_W  = FRACTION_BITS + 15;
  localparam int REPS_W = HND_W + 1;
  localparam logic signed [REP_W-1:0] HALF_TENTH = REP_W'(5) <<< FRACTION_BITS;
  localparam logic signed [REPS_W-1:0] HND_MAX = REPS_W'(8191);
  localparam logic signed [REPS_W-1:0] HND_MIN = -REPS_W'(8192);

  // Configuration register map.
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPACING    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOG_PERIOD = 2'd2;

  localparam logic [TIME_W-1:0] MS_PER_MINUTE = 32'd60000;
  localparam logic [TIME_W-1:0] SPACING_RESET = 32'd60000;

  typedef logic signed [FILT_W-1:0] filt_t;
  typedef logic signed [REPS_W-1:0] rep_t;

  // One filter step: y + floor((x - y) / 20).
  function automatic filt_t ema_step(filt_t y, filt_t x);
    filt_t d;
    logic neg;
    logic [MAG_W-1:0] mag;
    logic [MAG_W-1:0] mag_rnd;
    logic [DIVA_W-1:0] quarter;
    logic [PROD_W-1:0] prod;
    logic [QUO_W-1:0] quo;
    filt_t q;
    d = x - y;
    neg = d[FILT_W-1];
    mag = neg ? MAG_W'(-d) : MAG_W'(d);
    // Flooring a negative quotient rounds its magnitude up.
    mag_rnd = neg ? mag + ROUND_UP_19 : mag;
    quarter = mag_rnd[MAG_W-1:2];
    prod = PROD_W'(quarter) * PROD_W'(DIV5_RCP);
    quo = prod[PROD_W-1:DIV5_SHIFT];
    q = filt_t'(quo);
    if (neg) begin
      q = -q;
    end
    return y + q;
  endfunction

  // Hundredths report, truncated toward zero.
  function automatic rep_t report(filt_t y);
    logic signed [REP_W-1:0] ye;
    logic signed [REP_W-1:0] v;
    logic [REP_W-1:0] mag;
    rep_t r;
    ye = REP_W'(y);
    v = (ye <<< 3) + (ye <<< 1) + HALF_TENTH;
    mag = v[REP_W-1] ? REP_W'(-v) : REP_W'(v);
    r = rep_t'(mag[FRACTION_BITS +: HND_W]);
    return v[REP_W-1] ? -r : r;
  endfunction

  // Clamp a signed report to the 14-bit output range.
  function automatic logic signed [HND_W-1:0] sat_hnd(rep_t r);
    rep_t c;
    c = r;
    if (r > HND_MAX) begin
      c = HND_MAX;
    end else if (r < HND_MIN) begin
      c = HND_MIN;
    end
    return c[HND_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/sensor_sample_ema_scheduler.sv =====
`timescale 1ns / 1ps

// Sensor sample scheduler with humidity and temperature moving-average filters.
// Input channel (in_valid/in_ready) carries one timestamped reading per item.
// Result channel (out_valid/out_ready) carries a filtered report, or an error
// report when a due reading failed. Items that are not due produce no result.
// The cfg_wr_en/cfg_index/cfg_wdata port writes enable, the sample period in
// ms and the log period in minutes; write only while no item is in flight.
// Writing enable = 1 from idle starts the start/acquire/run sequence; 0 stops.
// A result passes through the input register, the filter update into a
// result register, and the report register.
// Throughput: one item per cycle unless the receiver stalls. The limit is the
// filter state loop, which closes through one reciprocal multiplier per filter.
// When the receiver stalls, the report register and the result register each
// hold one result, and one more item waits in the input register; in_ready
// drops only when all three are full.
// Reset (synchronous, rst_n low) empties the pipeline, puts the phase in
// idle, clears timestamps and filters, and restores the default periods.
module sensor_sample_ema_scheduler (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_wr_en,
  input  logic [sses_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [sses_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [sses_pkg::TIME_W-1:0]           in_now_ms,
  input  logic                                  in_read_ok,
  input  logic [sses_pkg::HUM_IN_W-1:0]         in_humidity_tenths,
  input  logic signed [sses_pkg::TMP_IN_W-1:0]  in_temperature_tenths,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  out_sensor_error,
  output logic [sses_pkg::HND_W-1:0]            out_humidity_hundredths,
  output logic signed [sses_pkg::HND_W-1:0]     out_temperature_hundredths,
  output logic                                  out_log_now
);

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_START   = 2'd1;
  localparam logic [1:0] PH_ACQUIRE = 2'd2;
  localparam logic [1:0] PH_RUN     = 2'd3;

  // Input register.
  logic                                 s0_valid_r;
  logic [sses_pkg::TIME_W-1:0]          s0_now_r;
  logic                                 s0_ok_r;
  logic [sses_pkg::HUM_IN_W-1:0]        s0_hum_r;
  logic signed [sses_pkg::TMP_IN_W-1:0] s0_tmp_r;

  // Scheduler and filter state.
  logic [1:0]                           phase_r, phase_nxt;
  logic [sses_pkg::TIME_W-1:0]          last_sample_r, last_sample_nxt;
  logic [sses_pkg::TIME_W-1:0]          last_log_r, last_log_nxt;
  logic [sses_pkg::HUM_W-1:0]           hum_filt_r, hum_filt_nxt;
  logic signed [sses_pkg::TMP_W-1:0]    tmp_filt_r, tmp_filt_nxt;

  // Configuration.
  logic [sses_pkg::TIME_W-1:0]          spacing_ms_r;
  logic [sses_pkg::TIME_W-1:0]          log_period_ms_r;

  // Result register (raw filter values).
  logic                                 s1_valid_r;
  logic                                 s1_err_r;
  logic                                 s1_log_r;
  logic [sses_pkg::HUM_W-1:0]           s1_hum_r;
  logic signed [sses_pkg::TMP_W-1:0]    s1_tmp_r;

  // Report register.
  logic                                 out_valid_r;
  logic                                 out_err_r;
  logic                                 out_log_r;
  logic [sses_pkg::HND_W-1:0]           out_hum_r;
  logic signed [sses_pkg::HND_W-1:0]    out_tmp_r;

  logic out_free, s1_free, s0_free, proc_go;
  logic res_emit, res_err, res_log;
  logic sample_due, log_due;
  sses_pkg::filt_t hum_x, tmp_x, hum_y, tmp_y, hum_ema, tmp_ema;
  sses_pkg::rep_t  hum_rep, tmp_rep;

  // Pipeline flow control: each stage moves when the next one is free.
  assign out_free = !out_valid_r || out_ready;
  assign s1_free  = !s1_valid_r || out_free;
  assign s0_free  = !s0_valid_r || s1_free;
  assign proc_go  = s0_valid_r && s1_free;
  assign in_ready = s0_free;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (s0_free) begin
      s0_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && s0_free) begin
      s0_now_r <= in_now_ms;
      s0_ok_r  <= in_read_ok;
      s0_hum_r <= in_humidity_tenths;
      s0_tmp_r <= in_temperature_tenths;
    end
  end

  // Readings and filters in the common signed working format.
  assign hum_x = sses_pkg::filt_t'({s0_hum_r, {sses_pkg::FRACTION_BITS{1'b0}}});
  assign tmp_x = sses_pkg::filt_t'($signed({s0_tmp_r, {sses_pkg::FRACTION_BITS{1'b0}}}));
  assign hum_y = sses_pkg::filt_t'(hum_filt_r);
  assign tmp_y = sses_pkg::filt_t'(tmp_filt_r);
  assign hum_ema = sses_pkg::ema_step(hum_y, hum_x);
  assign tmp_ema = sses_pkg::ema_step(tmp_y, tmp_x);

  // Elapsed-time checks use wrapping subtraction.
  assign sample_due = (s0_now_r - last_sample_r) > spacing_ms_r;
  assign log_due    = (s0_now_r - last_log_r) > log_period_ms_r;

  // Phase machine and filter update for the item in the input register.
  always_comb begin
    phase_nxt       = phase_r;
    last_sample_nxt = last_sample_r;
    last_log_nxt    = last_log_r;
    hum_filt_nxt    = hum_filt_r;
    tmp_filt_nxt    = tmp_filt_r;
    res_emit        = 1'b0;
    res_err         = 1'b0;
    res_log         = 1'b0;
    case (phase_r)
      PH_START: begin
        last_log_nxt = s0_now_r;
        phase_nxt    = PH_ACQUIRE;
      end
      PH_ACQUIRE: begin
        // The first good reading seeds both filters.
        if (s0_ok_r) begin
          hum_filt_nxt = hum_x[sses_pkg::HUM_W-1:0];
          tmp_filt_nxt = tmp_x;
          phase_nxt    = PH_RUN;
        end
      end
      PH_RUN: begin
        if (sample_due) begin
          last_sample_nxt = s0_now_r;
          res_emit        = 1'b1;
          if (!s0_ok_r) begin
            res_err = 1'b1;
          end else begin
            hum_filt_nxt = hum_ema[sses_pkg::HUM_W-1:0];
            tmp_filt_nxt = tmp_ema;
            if (log_due) begin
              res_log      = 1'b1;
              last_log_nxt = s0_now_r;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  // State registers; the user must write configuration only while no item is in flight; the block does not enforce it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      last_sample_r <= '0;
      last_log_r    <= '0;
      hum_filt_r    <= '0;
      tmp_filt_r    <= '0;
    end else if (cfg_wr_en) begin
      if (cfg_index == sses_pkg::REG_ENABLE) begin
        if (!cfg_wdata[0]) begin
          phase_r <= PH_IDLE;
        end else if (phase_r == PH_IDLE) begin
          phase_r <= PH_START;
        end
      end
    end else if (proc_go) begin
      phase_r       <= phase_nxt;
      last_sample_r <= last_sample_nxt;
      last_log_r    <= last_log_nxt;
      hum_filt_r    <= hum_filt_nxt;
      tmp_filt_r    <= tmp_filt_nxt;
    end
  end

  // Period registers; the log period is kept in milliseconds, mod 2^32.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spacing_ms_r    <= sses_pkg::SPACING_RESET;
      log_period_ms_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        sses_pkg::REG_SPACING: begin
          spacing_ms_r <= cfg_wdata[sses_pkg::TIME_W-1:0];
        end
        sses_pkg::REG_LOG_PERIOD: begin
          log_period_ms_r <= sses_pkg::TIME_W'(
              {{(sses_pkg::TIME_W - sses_pkg::LOG_MIN_W){1'b0}},
               cfg_wdata[sses_pkg::LOG_MIN_W-1:0]} * sses_pkg::MS_PER_MINUTE);
        end
        default: begin
        end
      endcase
    end
  end

  // Result register: flags and the filter values after this item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_free) begin
      s1_valid_r <= proc_go && res_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_go && res_emit) begin
      s1_err_r <= res_err;
      s1_log_r <= res_log;
      s1_hum_r <= hum_filt_nxt;
      s1_tmp_r <= tmp_filt_nxt;
    end
  end

  // Report conversion into hundredths.
  assign hum_rep = sses_pkg::report(sses_pkg::filt_t'(s1_hum_r));
  assign tmp_rep = sses_pkg::report(sses_pkg::filt_t'(s1_tmp_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid_r) begin
      out_err_r <= s1_err_r;
      out_log_r <= s1_log_r;
      out_hum_r <= hum_rep[sses_pkg::HND_W-1:0];
      out_tmp_r <= sses_pkg::sat_hnd(tmp_rep);
    end
  end

  assign out_valid                  = out_valid_r;
  assign out_sensor_error           = out_err_r;
  assign out_log_now                = out_log_r;
  assign out_humidity_hundredths    = out_hum_r;
  assign out_temperature_hundredths = out_tmp_r;

  // Results only come out of the run phase.
  a_emit_in_run: assert property (@(posedge clk) disable iff (!rst_n)
      (proc_go && res_emit) |-> (phase_r == PH_RUN))
    else $error("result produced outside the run phase");

  // A failed due reading leaves both filters untouched.
  a_err_keeps_filters: assert property (@(posedge clk) disable iff (!rst_n)
      (proc_go && res_emit && res_err) |=> ($stable(hum_filt_r) && $stable(tmp_filt_r)))
    else $error("filters changed on an error result");

  // An error result never carries the log flag.
  a_err_no_log: assert property (@(posedge clk) disable iff (!rst_n)
      s1_valid_r |-> !(s1_err_r && s1_log_r))
    else $error("error result flagged for logging");

  // A result held back by a full report register stays in the result register.
  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
      (s1_valid_r && !out_free) |=> (s1_valid_r && $stable(s1_hum_r) && $stable(s1_tmp_r)))
    else $error("stalled result lost from result register");

endmodule
